// ===== rtl/fbmt_pkg.sv =====
// shared types and constants for the function boundary mark table
// no dependencies; used by the interfaces, the cell chain and the top level
package fbmt_pkg;

  localparam int ADDR_W  = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int GRP     = 32;
  localparam int GRP_W   = 5;

  localparam logic [1:0] OP_SCAN   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [5:0]  PRIM_BRANCH = 6'd18;
  localparam logic [5:0]  PRIM_XL     = 6'd19;
  localparam logic [31:0] BRANCH_FIELD_MASK = 32'h03fffffc;
  localparam logic [31:0] BRANCH_SIGN_BIT   = 32'h02000000;
  localparam logic [31:0] BRANCH_SIGN_FILL  = 32'hfc000000;
  localparam logic [10:0] EXT_BCLR  = 11'd32;
  localparam logic [10:0] EXT_BCLRL = 11'd33;
  localparam logic [10:0] EXT_RFI   = 11'd100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_CMP,
    S_RED,
    S_CMT,
    S_RD1,
    S_RD2,
    S_DONE
  } state_t;

  // strobes and key broadcast from the sequencer to the cell row
  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic              kind;
    logic              cmp_en;
    logic              red_en;
    logic              commit;
    logic              rd1_en;
    logic              rd2_en;
  } ctl_t;

endpackage

// ===== rtl/fbmt_if.sv =====
// request and result channel interfaces of the mark table
// depends on fbmt_pkg for field widths
interface fbmt_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [fbmt_pkg::ADDR_W-1:0]   address;
  logic [31:0]                   opcode;
  logic                          first_in_range;
  logic                          is_exit;
  logic [fbmt_pkg::INDEX_W-1:0]  index;

  modport source (
    output valid, operation, address, opcode, first_in_range, is_exit, index,
    input  ready
  );
  modport sink (
    input  valid, operation, address, opcode, first_in_range, is_exit, index,
    output ready
  );
endinterface

interface fbmt_out_if;
  logic                          valid;
  logic                          ready;
  logic [fbmt_pkg::COUNT_W-1:0]  entry_count;
  logic [1:0]                    marks_added;
  logic                          dropped;
  logic [fbmt_pkg::ADDR_W-1:0]   read_offset;
  logic                          read_is_exit;
  logic                          read_valid;

  modport source (
    output valid, entry_count, marks_added, dropped, read_offset, read_is_exit,
           read_valid,
    input  ready
  );
  modport sink (
    input  valid, entry_count, marks_added, dropped, read_offset, read_is_exit,
           read_valid,
    output ready
  );
endinterface

// ===== rtl/fbmt_cell.sv =====
// one slot of the sorted mark row: compares against the broadcast key and
// shifts in from its left neighbor on insert; depends on fbmt_pkg
module fbmt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 11
) (
  input  logic                        clk,
  input  fbmt_pkg::ctl_t              ctl,
  input  logic [CNT_W-1:0]            total,
  input  logic [fbmt_pkg::ADDR_W-1:0] left_addr,
  input  logic                        left_kind,
  input  logic                        left_lt,
  output logic [fbmt_pkg::ADDR_W-1:0] addr_o,
  output logic                        kind_o,
  output logic                        lt_o,
  output logic                        eq_o
);

  logic [fbmt_pkg::ADDR_W-1:0] addr_r;
  logic                        kind_r;
  logic                        lt_r;
  logic                        eq_r;
  logic                        occupied;

  assign occupied = total > CNT_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r <= occupied && (addr_r < ctl.key);
      eq_r <= occupied && (addr_r == ctl.key);
    end
    // cells below the insertion point keep their mark
    if (ctl.commit && !lt_r) begin
      if (left_lt) begin
        addr_r <= ctl.key;
        kind_r <= ctl.kind;
      end else begin
        addr_r <= left_addr;
        kind_r <= left_kind;
      end
    end
  end

  assign addr_o = addr_r;
  assign kind_o = kind_r;
  assign lt_o   = lt_r;
  assign eq_o   = eq_r;

endmodule

// ===== rtl/fbmt_chain.sv =====
// row of mark cells with a registered group tree for the duplicate check
// and a two-level registered read select; depends on fbmt_pkg, fbmt_cell
module fbmt_chain #(
  parameter int CAPACITY = 1024,
  parameter int CNT_W    = 11
) (
  input  logic                         clk,
  input  fbmt_pkg::ctl_t               ctl,
  input  logic [CNT_W-1:0]             total,
  input  logic [fbmt_pkg::INDEX_W-1:0] rd_index,
  output logic                         dup,
  output logic [fbmt_pkg::ADDR_W-1:0]  rd_addr,
  output logic                         rd_kind
);

  localparam int NGRP = (CAPACITY + fbmt_pkg::GRP - 1) / fbmt_pkg::GRP;

  logic [fbmt_pkg::ADDR_W-1:0] cell_addr [CAPACITY];
  logic [CAPACITY-1:0]         cell_kind;
  logic [CAPACITY-1:0]         cell_lt;
  logic [CAPACITY-1:0]         cell_eq;

  logic [NGRP-1:0]             grp_hit_r;
  logic [fbmt_pkg::ADDR_W-1:0] grp_addr_r [NGRP];
  logic [NGRP-1:0]             grp_kind_r;
  logic [fbmt_pkg::ADDR_W-1:0] rd_addr_r;
  logic                        rd_kind_r;
  logic [fbmt_pkg::ADDR_W-1:0] rd_addr_nxt;
  logic                        rd_kind_nxt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [fbmt_pkg::ADDR_W-1:0] l_addr;
    logic                        l_kind;
    logic                        l_lt;
    if (i == 0) begin : g_head
      // the head cell takes the key whenever the key sorts first
      assign l_addr = ctl.key;
      assign l_kind = ctl.kind;
      assign l_lt   = 1'b1;
    end else begin : g_body
      assign l_addr = cell_addr[i-1];
      assign l_kind = cell_kind[i-1];
      assign l_lt   = cell_lt[i-1];
    end
    fbmt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .total     (total),
      .left_addr (l_addr),
      .left_kind (l_kind),
      .left_lt   (l_lt),
      .addr_o    (cell_addr[i]),
      .kind_o    (cell_kind[i]),
      .lt_o      (cell_lt[i]),
      .eq_o      (cell_eq[i])
    );
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [fbmt_pkg::ADDR_W-1:0] lane_addr [fbmt_pkg::GRP];
    logic [fbmt_pkg::GRP-1:0]    lane_kind;
    logic [fbmt_pkg::GRP-1:0]    lane_eq;
    logic [fbmt_pkg::ADDR_W-1:0] sel_addr;
    logic                        sel_kind;

    for (genvar j = 0; j < fbmt_pkg::GRP; j++) begin : g_lane
      if (g * fbmt_pkg::GRP + j < CAPACITY) begin : g_used
        assign lane_addr[j] = cell_addr[g*fbmt_pkg::GRP+j];
        assign lane_kind[j] = cell_kind[g*fbmt_pkg::GRP+j];
        assign lane_eq[j]   = cell_eq[g*fbmt_pkg::GRP+j];
      end else begin : g_pad
        assign lane_addr[j] = '0;
        assign lane_kind[j] = 1'b0;
        assign lane_eq[j]   = 1'b0;
      end
    end

    always_comb begin
      sel_addr = '0;
      sel_kind = 1'b0;
      for (int j = 0; j < fbmt_pkg::GRP; j++) begin
        if (rd_index[fbmt_pkg::GRP_W-1:0] == fbmt_pkg::GRP_W'(j)) begin
          sel_addr = lane_addr[j];
          sel_kind = lane_kind[j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.red_en) begin
        grp_hit_r[g] <= |lane_eq;
      end
      if (ctl.rd1_en) begin
        grp_addr_r[g] <= sel_addr;
        grp_kind_r[g] <= sel_kind;
      end
    end
  end

  always_comb begin
    rd_addr_nxt = '0;
    rd_kind_nxt = 1'b0;
    for (int g = 0; g < NGRP; g++) begin
      if (int'(rd_index[fbmt_pkg::INDEX_W-1:fbmt_pkg::GRP_W]) == g) begin
        rd_addr_nxt = grp_addr_r[g];
        rd_kind_nxt = grp_kind_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd2_en) begin
      rd_addr_r <= rd_addr_nxt;
      rd_kind_r <= rd_kind_nxt;
    end
  end

  assign dup     = |grp_hit_r;
  assign rd_addr = rd_addr_r;
  assign rd_kind = rd_kind_r;

endmodule

// ===== rtl/function_boundary_mark_table.sv =====
// Sorted table of code marks (address plus entry/exit kind) held in a row of
// cells, one mark per cell. An insert broadcasts its address to every cell,
// registers the per-cell compares, reduces the equal flags through a
// registered tree of 32-cell groups, then shifts the upper part of the row one
// cell to the right at once. Each item is handled mark by mark (a scan word
// tries up to two marks, an insert one); a read goes through the two-level
// select, and the unused operation code goes straight to the result.
// Each insert runs the compare, group reduction and shift steps in order.
// The result sits in an output register, so a new request is taken
// while the previous result still waits. No clearing pass is needed after
// reset: the cells are not cleared, only the mark count and control state.
// depends on fbmt_pkg, fbmt_if, fbmt_chain, fbmt_cell
module function_boundary_mark_table #(
  parameter int CAPACITY = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  fbmt_in_if.sink        in_chan,
  fbmt_out_if.source     out_chan
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  fbmt_pkg::state_t state_r, state_nxt;
  fbmt_pkg::ctl_t   ctl;

  logic [1:0]                    op_r;
  logic [fbmt_pkg::INDEX_W-1:0]  index_r;
  logic                          pend0_r, pend1_r;
  logic [fbmt_pkg::ADDR_W-1:0]   k0_addr_r, k1_addr_r, key_r;
  logic                          k0_kind_r, k1_kind_r, kind_r;
  logic [CNT_W-1:0]              total_r;
  logic [1:0]                    added_r;
  logic                          dropped_r;

  logic                          out_valid_r;
  logic [fbmt_pkg::COUNT_W-1:0]  out_count_r;
  logic [1:0]                    out_added_r;
  logic                          out_dropped_r;
  logic [fbmt_pkg::ADDR_W-1:0]   out_offset_r;
  logic                          out_is_exit_r;
  logic                          out_rd_valid_r;

  logic                          accept;
  logic                          out_load;
  logic                          dup;
  logic [fbmt_pkg::ADDR_W-1:0]   rd_addr;
  logic                          rd_kind;
  logic                          rd_ok;
  logic                          table_full;

  // scan decode
  logic [5:0]                    primary;
  logic [fbmt_pkg::ADDR_W-1:0]   br_disp;
  logic [fbmt_pkg::ADDR_W-1:0]   br_target;
  logic                          is_branch;
  logic                          is_ret;
  logic                          dec_en;
  logic [fbmt_pkg::ADDR_W-1:0]   dec_addr;
  logic                          dec_kind;

  assign accept   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = rst_n && (state_r == fbmt_pkg::S_IDLE);
  assign out_load = (state_r == fbmt_pkg::S_DONE) && (!out_valid_r || out_chan.ready);

  assign primary   = in_chan.opcode[31:26];
  assign br_disp   = (in_chan.opcode & fbmt_pkg::BRANCH_FIELD_MASK)
                   | (((in_chan.opcode & fbmt_pkg::BRANCH_SIGN_BIT) != '0)
                      ? fbmt_pkg::BRANCH_SIGN_FILL : '0);
  // relative form adds the word's own address, wrapping
  assign br_target = in_chan.opcode[1] ? br_disp : br_disp + in_chan.address;
  assign is_branch = (primary == fbmt_pkg::PRIM_BRANCH) && in_chan.opcode[0];
  assign is_ret    = (primary == fbmt_pkg::PRIM_XL)
                  && ((in_chan.opcode[10:0] == fbmt_pkg::EXT_BCLR)
                   || (in_chan.opcode[10:0] == fbmt_pkg::EXT_BCLRL)
                   || (in_chan.opcode[10:0] == fbmt_pkg::EXT_RFI));
  assign dec_en    = is_branch || is_ret;
  assign dec_addr  = is_branch ? br_target : in_chan.address;
  assign dec_kind  = !is_branch;

  assign table_full = (total_r == CNT_W'(CAPACITY));
  assign rd_ok      = (32'(index_r) < 32'(total_r));

  always_comb begin
    state_nxt  = state_r;
    ctl.key    = key_r;
    ctl.kind   = kind_r;
    ctl.cmp_en = 1'b0;
    ctl.red_en = 1'b0;
    ctl.commit = 1'b0;
    ctl.rd1_en = 1'b0;
    ctl.rd2_en = 1'b0;
    case (state_r)
      fbmt_pkg::S_IDLE: begin
        if (accept) begin
          case (in_chan.operation)
            fbmt_pkg::OP_SCAN, fbmt_pkg::OP_INSERT: state_nxt = fbmt_pkg::S_NEXT;
            fbmt_pkg::OP_READ:                      state_nxt = fbmt_pkg::S_RD1;
            default:                                state_nxt = fbmt_pkg::S_DONE;
          endcase
        end
      end
      fbmt_pkg::S_NEXT: begin
        state_nxt = (pend0_r || pend1_r) ? fbmt_pkg::S_CMP : fbmt_pkg::S_DONE;
      end
      fbmt_pkg::S_CMP: begin
        ctl.cmp_en = 1'b1;
        state_nxt  = fbmt_pkg::S_RED;
      end
      fbmt_pkg::S_RED: begin
        ctl.red_en = 1'b1;
        state_nxt  = fbmt_pkg::S_CMT;
      end
      fbmt_pkg::S_CMT: begin
        ctl.commit = !dup && !table_full;
        state_nxt  = fbmt_pkg::S_NEXT;
      end
      fbmt_pkg::S_RD1: begin
        ctl.rd1_en = 1'b1;
        state_nxt  = fbmt_pkg::S_RD2;
      end
      fbmt_pkg::S_RD2: begin
        ctl.rd2_en = 1'b1;
        state_nxt  = fbmt_pkg::S_DONE;
      end
      fbmt_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = fbmt_pkg::S_IDLE;
        end
      end
      default: state_nxt = fbmt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbmt_pkg::S_IDLE;
      total_r     <= '0;
      pend0_r     <= 1'b0;
      pend1_r     <= 1'b0;
      added_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        added_r   <= '0;
        dropped_r <= 1'b0;
        if (in_chan.operation == fbmt_pkg::OP_SCAN) begin
          pend0_r <= in_chan.first_in_range || dec_en;
          pend1_r <= in_chan.first_in_range && dec_en;
        end else if (in_chan.operation == fbmt_pkg::OP_INSERT) begin
          pend0_r <= 1'b1;
          pend1_r <= 1'b0;
        end else begin
          pend0_r <= 1'b0;
          pend1_r <= 1'b0;
        end
      end
      if (state_r == fbmt_pkg::S_NEXT) begin
        if (pend0_r) begin
          pend0_r <= 1'b0;
        end else begin
          pend1_r <= 1'b0;
        end
      end
      if (state_r == fbmt_pkg::S_CMT && !dup) begin
        if (table_full) begin
          dropped_r <= 1'b1;
        end else begin
          total_r <= CNT_W'(total_r + 1'b1);
          added_r <= added_r + 2'd1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_chan.operation;
      index_r <= in_chan.index;
      if (in_chan.operation == fbmt_pkg::OP_SCAN) begin
        if (in_chan.first_in_range) begin
          k0_addr_r <= in_chan.address;
          k0_kind_r <= 1'b0;
        end else begin
          k0_addr_r <= dec_addr;
          k0_kind_r <= dec_kind;
        end
        k1_addr_r <= dec_addr;
        k1_kind_r <= dec_kind;
      end else begin
        k0_addr_r <= in_chan.address;
        k0_kind_r <= in_chan.is_exit;
        k1_addr_r <= in_chan.address;
        k1_kind_r <= in_chan.is_exit;
      end
    end
    if (state_r == fbmt_pkg::S_NEXT) begin
      key_r  <= pend0_r ? k0_addr_r : k1_addr_r;
      kind_r <= pend0_r ? k0_kind_r : k1_kind_r;
    end
    if (out_load) begin
      out_count_r   <= fbmt_pkg::COUNT_W'(total_r);
      out_added_r   <= added_r;
      out_dropped_r <= dropped_r;
      if (op_r == fbmt_pkg::OP_READ && rd_ok) begin
        out_offset_r   <= rd_addr;
        out_is_exit_r  <= rd_kind;
        out_rd_valid_r <= 1'b1;
      end else begin
        out_offset_r   <= '0;
        out_is_exit_r  <= 1'b0;
        out_rd_valid_r <= 1'b0;
      end
    end
  end

  fbmt_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .total    (total_r),
    .rd_index (index_r),
    .dup      (dup),
    .rd_addr  (rd_addr),
    .rd_kind  (rd_kind)
  );

  assign out_chan.valid        = out_valid_r;
  assign out_chan.entry_count  = out_count_r;
  assign out_chan.marks_added  = out_added_r;
  assign out_chan.dropped      = out_dropped_r;
  assign out_chan.read_offset  = out_offset_r;
  assign out_chan.read_is_exit = out_is_exit_r;
  assign out_chan.read_valid   = out_rd_valid_r;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for function_boundary_mark_table: directed, stall, random, fill and full-table requests
// a sorted mark table model in this file predicts every result
// depends on fbmt_pkg, fbmt_if and the rtl of the mark table
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH     = 1024;
  localparam int RANDOM_REQUESTS = 250;
  localparam int FULL_REQUESTS   = 40;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 24;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [10:0] EXT_OTHER = 11'd16;
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  typedef struct packed {
    logic [1:0]                   operation;
    logic [fbmt_pkg::ADDR_W-1:0]  address;
    logic [31:0]                  opcode;
    logic                         first_in_range;
    logic                         is_exit;
    logic [fbmt_pkg::INDEX_W-1:0] index;
  } mark_req_t;

  typedef struct packed {
    logic [fbmt_pkg::COUNT_W-1:0] entry_count;
    logic [1:0]                   marks_added;
    logic                         dropped;
    logic [fbmt_pkg::ADDR_W-1:0]  read_offset;
    logic                         read_is_exit;
    logic                         read_valid;
  } table_result_t;

  typedef struct packed {
    logic [fbmt_pkg::ADDR_W-1:0] addr;
    logic                        kind;
  } mark_t;

  logic clk;
  logic rst_n;
  fbmt_in_if  in_chan ();
  fbmt_out_if out_chan ();

  mark_t         marks[$];
  table_result_t pending_table_results[$];
  int error_count = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int hold_off_asked = 0;
  int cycle_count = 0;

  function_boundary_mark_table #(.CAPACITY(TABLE_DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // sorted insert; duplicates leave the table untouched, a full table refuses new addresses
  function automatic void place_mark(input logic [fbmt_pkg::ADDR_W-1:0] addr,
                                     input logic kind, inout int added, inout logic full);
    int pos;
    mark_t m;
    pos = 0;
    while (pos < marks.size() && marks[pos].addr < addr) pos++;
    if (pos < marks.size() && marks[pos].addr == addr) return;
    if (marks.size() >= TABLE_DEPTH) begin
      full = 1'b1;
      return;
    end
    m.addr = addr;
    m.kind = kind;
    marks.insert(pos, m);
    added++;
  endfunction

  function automatic table_result_t mark_table_step(input mark_req_t req);
    table_result_t res;
    int added;
    int held;
    logic full;
    logic [fbmt_pkg::ADDR_W-1:0] target;
    logic [10:0] ext;
    res = '0;
    added = 0;
    full = 1'b0;
    case (req.operation)
      fbmt_pkg::OP_SCAN: begin
        if (req.first_in_range) place_mark(req.address, KIND_ENTRY, added, full);
        if (req.opcode[31:26] == fbmt_pkg::PRIM_BRANCH && req.opcode[0]) begin
          target = req.opcode & fbmt_pkg::BRANCH_FIELD_MASK;
          if ((target & fbmt_pkg::BRANCH_SIGN_BIT) != '0)
            target = target | fbmt_pkg::BRANCH_SIGN_FILL;
          // relative link branch: target wraps modulo 2^32
          if (!req.opcode[1]) target = target + req.address;
          place_mark(target, KIND_ENTRY, added, full);
        end else if (req.opcode[31:26] == fbmt_pkg::PRIM_XL) begin
          ext = req.opcode[10:0];
          if (ext == fbmt_pkg::EXT_BCLR || ext == fbmt_pkg::EXT_BCLRL
              || ext == fbmt_pkg::EXT_RFI)
            place_mark(req.address, KIND_EXIT, added, full);
        end
      end
      fbmt_pkg::OP_INSERT: place_mark(req.address, req.is_exit, added, full);
      fbmt_pkg::OP_READ: begin
        if (req.index < marks.size()) begin
          res.read_valid   = 1'b1;
          res.read_offset  = marks[req.index].addr;
          res.read_is_exit = marks[req.index].kind;
        end
      end
      default: ;
    endcase
    held = marks.size();
    res.entry_count = held[fbmt_pkg::COUNT_W-1:0];
    res.marks_added = added[1:0];
    res.dropped     = full;
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_table_result();
    table_result_t want;
    if (pending_table_results.size() == 0) begin
      $display("%0t ns: result with nothing expected, actual entry_count %0d", $time,
               out_chan.entry_count);
      error_count++;
    end else begin
      want = pending_table_results.pop_front();
      compare_field("entry_count", 32'(want.entry_count), 32'(out_chan.entry_count));
      compare_field("marks_added", 32'(want.marks_added), 32'(out_chan.marks_added));
      compare_field("dropped", 32'(want.dropped), 32'(out_chan.dropped));
      compare_field("read_offset", want.read_offset, out_chan.read_offset);
      compare_field("read_is_exit", 32'(want.read_is_exit), 32'(out_chan.read_is_exit));
      compare_field("read_valid", 32'(want.read_valid), 32'(out_chan.read_valid));
    end
  endtask

  function automatic mark_req_t build_request(input logic [1:0] op, input logic [31:0] addr,
                                              input logic [31:0] word, input logic first,
                                              input logic kind,
                                              input logic [fbmt_pkg::INDEX_W-1:0] idx);
    mark_req_t req;
    req.operation      = op;
    req.address        = addr;
    req.opcode         = word;
    req.first_in_range = first;
    req.is_exit        = kind;
    req.index          = idx;
    return req;
  endfunction

  function automatic logic [31:0] branch_word(input logic [23:0] li, input logic aa,
                                              input logic lk);
    return {fbmt_pkg::PRIM_BRANCH, li, aa, lk};
  endfunction

  function automatic logic [31:0] xl_word(input logic [10:0] ext);
    logic [14:0] mid;
    mid = 15'($urandom());
    return {fbmt_pkg::PRIM_XL, mid, ext};
  endfunction

  // reuse table addresses for duplicates, a dense code region for near misses
  function automatic logic [31:0] pick_address();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30 && marks.size() > 0) return marks[$urandom_range(0, marks.size() - 1)].addr;
    if (roll < 60) return 32'h8000_0000 | ($urandom_range(0, 4095) << 2);
    return $urandom();
  endfunction

  function automatic logic [31:0] scan_word();
    logic [23:0] li;
    logic [10:0] ext;
    logic aa;
    int roll;
    li = 24'($urandom());
    if ($urandom_range(0, 1) == 1) li = 24'($urandom_range(0, 511) - 256);
    aa = 1'($urandom_range(0, 1));
    ext = 11'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < 35) return branch_word(li, aa, 1'b1);
    if (roll < 45) return branch_word(li, aa, 1'b0);
    if (roll < 70) begin
      case ($urandom_range(0, 3))
        0: ext = fbmt_pkg::EXT_BCLR;
        1: ext = fbmt_pkg::EXT_BCLRL;
        2: ext = fbmt_pkg::EXT_RFI;
        default: ;
      endcase
      return xl_word(ext);
    end
    return $urandom();
  endfunction

  function automatic mark_req_t random_request();
    mark_req_t req;
    int roll;
    req.operation      = fbmt_pkg::OP_SCAN;
    req.address        = $urandom();
    req.opcode         = $urandom();
    req.first_in_range = 1'($urandom_range(0, 1));
    req.is_exit        = 1'($urandom_range(0, 1));
    req.index          = fbmt_pkg::INDEX_W'($urandom_range(0, 1023));
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      req.address = pick_address();
      req.opcode  = scan_word();
    end else if (roll < 78) begin
      req.operation = fbmt_pkg::OP_INSERT;
      req.address   = pick_address();
    end else if (roll < 97) begin
      req.operation = fbmt_pkg::OP_READ;
      if (marks.size() > 0 && $urandom_range(0, 3) != 0)
        req.index = fbmt_pkg::INDEX_W'($urandom_range(0, marks.size() - 1));
    end else begin
      req.operation = OP_SPARE;
    end
    return req;
  endfunction

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_request(input mark_req_t req);
    int gap;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.operation      <= req.operation;
    in_chan.address        <= req.address;
    in_chan.opcode         <= req.opcode;
    in_chan.first_in_range <= req.first_in_range;
    in_chan.is_exit        <= req.is_exit;
    in_chan.index          <= req.index;
    do @(posedge clk); while (!in_chan.ready);
    pending_table_results.push_back(mark_table_step(req));
  endtask

  task automatic send_scan(input logic [31:0] addr, input logic [31:0] word,
                           input logic first);
    send_request(build_request(fbmt_pkg::OP_SCAN, addr, word, first, 1'b0, '0));
  endtask

  task automatic send_read(input int idx);
    send_request(build_request(fbmt_pkg::OP_READ, $urandom(), $urandom(), 1'b0, 1'b0,
                               idx[fbmt_pkg::INDEX_W-1:0]));
  endtask

  task automatic test_directed_cases();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_read(0);
    send_request(build_request(fbmt_pkg::OP_READ, '1, '1, 1'b1, 1'b1, '1));
    // spare operation code only reports the count
    send_request(build_request(OP_SPARE, 32'h1234, '1, 1'b1, 1'b1, '1));
    send_request(build_request(fbmt_pkg::OP_INSERT, 32'h0, 32'h0, 1'b0, KIND_ENTRY, '0));
    send_request(build_request(fbmt_pkg::OP_INSERT, 32'hffff_ffff, '1, 1'b1, KIND_EXIT,
                               '1));
    // duplicate address keeps the old kind
    send_request(build_request(fbmt_pkg::OP_INSERT, 32'h0, 32'h0, 1'b0, KIND_EXIT, '0));
    // entry and exit on one address: the exit is a duplicate
    send_scan(32'h1000, xl_word(fbmt_pkg::EXT_BCLR), 1'b1);
    send_scan(32'h2000, xl_word(fbmt_pkg::EXT_BCLRL), 1'b0);
    send_scan(32'h3000, xl_word(fbmt_pkg::EXT_RFI), 1'b0);
    send_scan(32'h3800, xl_word(EXT_OTHER), 1'b0);
    send_scan(32'h4000, branch_word(24'h000040, 1'b0, 1'b1), 1'b0);
    send_scan(32'h5000, branch_word(24'hfffff0, 1'b0, 1'b1), 1'b0);
    // absolute target with sign fill
    send_scan(32'h6000, branch_word(24'h800000, 1'b1, 1'b1), 1'b0);
    // relative targets wrapping past the top and below zero
    send_scan(32'hffff_fff0, branch_word(24'h000008, 1'b0, 1'b1), 1'b0);
    send_scan(32'h0000_0008, branch_word(24'hfffffc, 1'b0, 1'b1), 1'b0);
    send_scan(32'h7000, branch_word(24'h000100, 1'b0, 1'b0), 1'b1);
    send_scan(32'h9000, branch_word(24'h000200, 1'b0, 1'b1), 1'b1);
    send_scan(32'ha000, 32'hffff_ffff, 1'b0);
    send_scan(32'hb000, 32'h0, 1'b1);
    send_read(0);
    send_read(1);
    send_read(marks.size() - 1);
    send_read(marks.size());
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // long receiver hold-off while requests keep coming back to back
  task automatic test_stalled_output();
    int i;
    send_idle = 1'b0;
    hold_off_asked++;
    for (i = 0; i < 30; i++) send_request(random_request());
    send_idle = 1'b1;
  endtask

  task automatic test_random_requests();
    int i;
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 60 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      send_request(random_request());
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_fill_to_capacity();
    mark_req_t req;
    while (marks.size() < TABLE_DEPTH) begin
      req = random_request();
      if ($urandom_range(0, 7) != 0) begin
        // entry at the word plus a linked branch target, up to two new marks per request
        req = build_request(fbmt_pkg::OP_SCAN, $urandom(),
                            branch_word(24'($urandom()), 1'($urandom()), 1'b1), 1'b1,
                            1'b0, '0);
      end
      send_request(req);
    end
  endtask

  task automatic test_full_table();
    int i;
    send_read(TABLE_DEPTH - 1);
    send_scan($urandom(), branch_word(24'($urandom()), 1'b1, 1'b1), 1'b1);
    for (i = 0; i < FULL_REQUESTS; i++) send_request(random_request());
    send_read(TABLE_DEPTH - 1);
  endtask

  initial begin : result_side
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left = 0;
    hold_seen = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) check_table_result();
      if (hold_off_asked != hold_seen) begin
        hold_seen = hold_off_asked;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        stall_left = recv_idle ? pick_gap() : 0;
        out_chan.ready <= (stall_left == 0);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("function_boundary_mark_table verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.operation      <= fbmt_pkg::OP_SCAN;
    in_chan.address        <= '0;
    in_chan.opcode         <= '0;
    in_chan.first_in_range <= 1'b0;
    in_chan.is_exit        <= 1'b0;
    in_chan.index          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_stalled_output();
    test_random_requests();
    test_fill_to_capacity();
    test_full_table();
    in_chan.valid <= 1'b0;
    while (pending_table_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("function_boundary_mark_table verification clean");
    end else begin
      $display("function_boundary_mark_table verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fbmt_pkg.sv
rtl/fbmt_if.sv
rtl/fbmt_cell.sv
rtl/fbmt_chain.sv
rtl/function_boundary_mark_table.sv
sim/testbench.sv
